### rtl/core/snfce_pkg.sv
// ----------------------------------------------------------------------------
// snfce_pkg
// Shared opcodes, register indexes, reset values and the control/status
// bundles between the command controller and the datapath.
// ----------------------------------------------------------------------------
package snfce_pkg;

  // Serial flash opcodes
  localparam logic [7:0] OP_WREN = 8'h06;
  localparam logic [7:0] OP_WRDI = 8'h04;
  localparam logic [7:0] OP_RDID = 8'h9F;
  localparam logic [7:0] OP_RDSR = 8'h05;
  localparam logic [7:0] OP_WRSR = 8'h01;
  localparam logic [7:0] OP_READ = 8'h03;
  localparam logic [7:0] OP_FAST = 8'h0B;
  localparam logic [7:0] OP_PP   = 8'h02;
  localparam logic [7:0] OP_SE   = 8'hD8;
  localparam logic [7:0] OP_BE   = 8'hC7;
  localparam logic [7:0] OP_DP   = 8'hB9;
  localparam logic [7:0] OP_RES  = 8'hAB;
  localparam logic [7:0] OP_NOP  = 8'h00;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_MFR_ID     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_JEDEC_EXT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECTOR_LOG = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_LOG = 3'd3;

  localparam logic [23:0] MFR_ID_RST     = 24'h202014;
  localparam logic [15:0] JEDEC_EXT_RST  = 16'h0000;
  localparam logic [4:0]  SECTOR_LOG_RST = 5'd16;
  localparam logic [4:0]  DEVICE_LOG_RST = 5'd20;

  // Byte counts for the collect and buffered-read phases
  localparam int          BUF_DEPTH  = 5;
  localparam logic [2:0]  NEED_ID    = 3'd5;
  localparam logic [2:0]  NEED_ONE   = 3'd1;
  localparam logic [2:0]  NEED_ADDR  = 3'd3;
  localparam logic [2:0]  NEED_FAST  = 3'd4;

  // Controller -> datapath
  typedef struct packed {
    logic capture;     // latch the input beat
    logic exec;        // run one protocol step
    logic load;        // move the pending result into the output register
    logic sweep_step;  // zero one storage byte
  } snfce_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic slot_free;      // output register empty or draining this cycle
    logic sweep_pending;  // zeroing bytes still to go
    logic sweep_last;     // this sweep step is the final one
  } snfce_stat_t;

endpackage

### rtl/core/spi_nor_flash_command_engine.sv
// ----------------------------------------------------------------------------
// spi_nor_flash_command_engine
// A beat is captured on acceptance and executed in the next cycle; its result
//   is held as pending and loaded into the output register once that is free;
//   storage reads use the registered memory read port.
// A new beat is taken only once the last result is loaded and any sweep ends;
//   bulk erase zeroes 2^device_log2 bytes and sector erase 2^sector_log2, with
//   sizes capped to the array (one byte zeroed/cycle). Reset: a clearing pass
//   zeroes all 2^ADDR_BITS bytes, one per cycle, with in_ready low; config is still taken.
// ----------------------------------------------------------------------------
// Serial NOR flash slave model in RTL. Each input beat is one SPI byte with
// chip select low, or a deselect event. Every beat yields exactly one result
// beat (miso byte plus driven flag).
//
// Structure:
//   snfce_ctrl - sequencer (sweep / idle / execute / result)
//   snfce_dp   - config registers, command protocol state, storage array,
//                zeroing sweep engine, output register
//
// Erases zero storage through the sweep engine after the result beat has
// been handed to the output register; no input is taken until the sweep ends,
// so later reads always see the erased bytes.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_engine #(
  parameter int ADDR_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [snfce_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [snfce_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input beats
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               action,
  input  logic [7:0]                         mosi,
  // result beats
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         miso,
  output logic                               miso_driven
);

  snfce_pkg::snfce_cmd_t  cmd;
  snfce_pkg::snfce_stat_t status;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;

  snfce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  snfce_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .mosi        (mosi),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .miso        (miso),
    .miso_driven (miso_driven),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

### rtl/core/snfce_ctrl.sv
// ----------------------------------------------------------------------------
// snfce_ctrl
// Sequencer: accept a beat, run one protocol step, hand the result to the
// output register, then run any pending zeroing sweep.
// ----------------------------------------------------------------------------
module snfce_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  snfce_pkg::snfce_stat_t status,
  output snfce_pkg::snfce_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC,
    S_RESULT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      unique case (state)
        S_SWEEP: begin
          if (status.sweep_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (status.slot_free) state <= status.sweep_pending ? S_SWEEP : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state == S_IDLE) && in_valid;
    cmd.exec       = (state == S_EXEC);
    cmd.load       = (state == S_RESULT) && status.slot_free;
    cmd.sweep_step = (state == S_SWEEP);
  end

`ifndef SYNTHESIS
  a_sweep_has_work: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_step |-> status.sweep_pending)
    else $error("sweep step with no bytes left");

  a_no_accept_during_erase: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !status.sweep_pending)
    else $error("ready while zeroing sweep pending");

  a_ready_source: assert property (@(posedge clk) disable iff (rst)
    $rose(in_ready) |-> ($past(cmd.load) || $past(cmd.sweep_step)))
    else $error("ready rose without result load or sweep end");
`endif

endmodule

### rtl/core/snfce_dp.sv
// ----------------------------------------------------------------------------
// snfce_dp
// Datapath: configuration registers, command protocol state, byte storage,
// zeroing sweep and the output register.
// ----------------------------------------------------------------------------
module snfce_dp #(
  parameter int ADDR_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [snfce_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [snfce_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               action,
  input  logic [7:0]                         mosi,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [7:0]                         miso,
  output logic                               miso_driven,
  input  snfce_pkg::snfce_cmd_t              cmd,
  output snfce_pkg::snfce_stat_t             status
);

  localparam int DEPTH = 1 << ADDR_BITS;
  localparam int CNT_W = ADDR_BITS + 1;
  localparam int BUF_DEPTH_L = snfce_pkg::BUF_DEPTH;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COLLECT,
    PH_PROGRAM,
    PH_READ_STORE,
    PH_READ_BUF
  } phase_t;

  // Configuration
  logic [23:0] mfr_dev_id;
  logic [15:0] jedec_ext;
  logic [4:0]  sector_log2;
  logic [4:0]  device_log2;

  // Captured beat
  logic       cur_action;
  logic [7:0] cur_mosi;

  // Protocol state
  phase_t                 phase, phase_next;
  logic [7:0]             opcode, opcode_next;
  logic                   wel, wel_next;
  logic [ADDR_BITS-1:0]   byte_address, byte_address_next;
  logic [7:0]             collect_buf [BUF_DEPTH_L];
  logic [7:0]             collect_buf_next [BUF_DEPTH_L];
  logic [2:0]             collected_count, collected_count_next;
  logic [2:0]             needed_count, needed_count_next;
  logic [2:0]             read_position, read_position_next;

  // Storage and sweep
  logic [7:0]           mem [DEPTH];
  logic [7:0]           rd_data;
  logic [ADDR_BITS-1:0] sweep_addr;
  logic [CNT_W-1:0]     sweep_left;

  // Pending result
  logic [7:0] pend_miso;
  logic       pend_drv;
  logic       pend_mem;

  // Step outputs
  logic [7:0]           res_miso;
  logic                 res_drv, res_mem, mem_rd, mem_wr, erase_go;
  logic [ADDR_BITS-1:0] erase_base;
  logic [CNT_W-1:0]     erase_span;

  // Derived geometry
  logic [4:0]           dev_log2, sec_log2;
  logic [CNT_W-1:0]     dev_span, sec_span;
  logic [ADDR_BITS-1:0] dev_mask, addr_use, addr_inc;
  logic [7:0]           b0, b1, b2;
  logic [23:0]          col_addr24;
  logic [ADDR_BITS-1:0] col_addr;
  logic [2:0]           cc_inc, rp_inc;

  // Storage write port
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [7:0]           wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      mfr_dev_id  <= snfce_pkg::MFR_ID_RST;
      jedec_ext   <= snfce_pkg::JEDEC_EXT_RST;
      sector_log2 <= snfce_pkg::SECTOR_LOG_RST;
      device_log2 <= snfce_pkg::DEVICE_LOG_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        snfce_pkg::CFG_MFR_ID:     mfr_dev_id  <= cfg_data;
        snfce_pkg::CFG_JEDEC_EXT:  jedec_ext   <= cfg_data[15:0];
        snfce_pkg::CFG_SECTOR_LOG: sector_log2 <= cfg_data[4:0];
        snfce_pkg::CFG_DEVICE_LOG: device_log2 <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dev_log2 = (device_log2 > 5'(ADDR_BITS)) ? 5'(ADDR_BITS) : device_log2;
    sec_log2 = (sector_log2 > dev_log2) ? dev_log2 : sector_log2;
    dev_span = CNT_W'(1) << dev_log2;
    sec_span = CNT_W'(1) << sec_log2;
    dev_mask = ADDR_BITS'(dev_span - CNT_W'(1));
    addr_use = byte_address & dev_mask;
    addr_inc = (addr_use + ADDR_BITS'(1)) & dev_mask;
    // address bytes, with the byte arriving now merged in
    b0 = (collected_count == 3'd0) ? cur_mosi : collect_buf[0];
    b1 = (collected_count == 3'd1) ? cur_mosi : collect_buf[1];
    b2 = (collected_count == 3'd2) ? cur_mosi : collect_buf[2];
    col_addr24 = {b0, b1, b2};
    col_addr   = col_addr24[ADDR_BITS-1:0] & dev_mask;
    cc_inc = collected_count + 3'd1;
    rp_inc = read_position + 3'd1;
  end

  // One protocol step for the captured beat
  always_comb begin
    phase_next           = phase;
    opcode_next          = opcode;
    wel_next             = wel;
    byte_address_next    = byte_address;
    collected_count_next = collected_count;
    needed_count_next    = needed_count;
    read_position_next   = read_position;
    collect_buf_next     = collect_buf;
    res_miso   = 8'h00;
    res_drv    = 1'b0;
    res_mem    = 1'b0;
    mem_rd     = 1'b0;
    mem_wr     = 1'b0;
    erase_go   = 1'b0;
    erase_base = '0;
    erase_span = '0;

    if (cur_action) begin
      phase_next           = PH_IDLE;
      collected_count_next = 3'd0;
      needed_count_next    = 3'd0;
      read_position_next   = 3'd0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          opcode_next          = cur_mosi;
          collected_count_next = 3'd0;
          needed_count_next    = 3'd0;
          read_position_next   = 3'd0;
          unique case (cur_mosi) inside
            snfce_pkg::OP_WREN: wel_next = 1'b1;
            snfce_pkg::OP_WRDI: wel_next = 1'b0;
            snfce_pkg::OP_RDID: begin
              collect_buf_next[0] = mfr_dev_id[23:16];
              collect_buf_next[1] = mfr_dev_id[15:8];
              collect_buf_next[2] = mfr_dev_id[7:0];
              collect_buf_next[3] = jedec_ext[15:8];
              collect_buf_next[4] = jedec_ext[7:0];
              phase_next          = PH_READ_BUF;
              needed_count_next   = snfce_pkg::NEED_ID;
            end
            snfce_pkg::OP_RDSR: begin
              collect_buf_next[0] = {6'b0, wel, 1'b0};
              phase_next          = PH_READ_BUF;
              needed_count_next   = snfce_pkg::NEED_ONE;
            end
            snfce_pkg::OP_WRSR: begin
              if (wel) begin
                phase_next        = PH_COLLECT;
                needed_count_next = snfce_pkg::NEED_ONE;
              end
            end
            snfce_pkg::OP_FAST: begin
              phase_next        = PH_COLLECT;
              needed_count_next = snfce_pkg::NEED_FAST;
            end
            snfce_pkg::OP_READ, snfce_pkg::OP_PP, snfce_pkg::OP_SE: begin
              phase_next        = PH_COLLECT;
              needed_count_next = snfce_pkg::NEED_ADDR;
            end
            snfce_pkg::OP_BE: begin
              erase_go   = 1'b1;
              erase_span = dev_span;
            end
            snfce_pkg::OP_DP, snfce_pkg::OP_RES, snfce_pkg::OP_NOP: ;
            default: opcode_next = snfce_pkg::OP_NOP;
          endcase
        end
        PH_COLLECT: begin
          if (collected_count < 3'(snfce_pkg::BUF_DEPTH)) begin
            collect_buf_next[collected_count] = cur_mosi;
          end
          collected_count_next = cc_inc;
          if (cc_inc >= needed_count) begin
            if (opcode == snfce_pkg::OP_WRSR) begin
              // status write is dropped
              phase_next           = PH_IDLE;
              collected_count_next = 3'd0;
              needed_count_next    = 3'd0;
              read_position_next   = 3'd0;
            end else begin
              byte_address_next    = col_addr;
              collected_count_next = 3'd0;
              case (opcode) inside
                snfce_pkg::OP_READ, snfce_pkg::OP_FAST: phase_next = PH_READ_STORE;
                snfce_pkg::OP_PP: phase_next = PH_PROGRAM;
                default: begin
                  if (opcode == snfce_pkg::OP_SE) begin
                    erase_go   = 1'b1;
                    erase_span = sec_span;
                    erase_base = col_addr & ~ADDR_BITS'(sec_span - CNT_W'(1));
                  end
                  phase_next         = PH_IDLE;
                  needed_count_next  = 3'd0;
                  read_position_next = 3'd0;
                end
              endcase
            end
          end
        end
        PH_PROGRAM: begin
          if (wel) begin
            mem_wr            = 1'b1;
            byte_address_next = addr_inc;
          end
        end
        PH_READ_STORE: begin
          mem_rd            = 1'b1;
          res_drv           = 1'b1;
          res_mem           = 1'b1;
          byte_address_next = addr_inc;
        end
        PH_READ_BUF: begin
          if (read_position < 3'(snfce_pkg::BUF_DEPTH)) begin
            res_miso = collect_buf[read_position];
          end
          res_drv            = 1'b1;
          read_position_next = rp_inc;
          if (rp_inc >= needed_count) begin
            phase_next           = PH_IDLE;
            collected_count_next = 3'd0;
            needed_count_next    = 3'd0;
            read_position_next   = 3'd0;
          end
        end
        default: begin
          phase_next           = PH_IDLE;
          collected_count_next = 3'd0;
          needed_count_next    = 3'd0;
          read_position_next   = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_action <= action;
      cur_mosi   <= mosi;
    end
    if (cmd.exec) begin
      collect_buf <= collect_buf_next;
      pend_miso   <= res_miso;
      pend_drv    <= res_drv;
      pend_mem    <= res_mem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      opcode          <= snfce_pkg::OP_NOP;
      wel             <= 1'b0;
      byte_address    <= '0;
      collected_count <= 3'd0;
      needed_count    <= 3'd0;
      read_position   <= 3'd0;
    end else if (cmd.exec) begin
      phase           <= phase_next;
      opcode          <= opcode_next;
      wel             <= wel_next;
      byte_address    <= byte_address_next;
      collected_count <= collected_count_next;
      needed_count    <= needed_count_next;
      read_position   <= read_position_next;
    end
  end

  // Zeroing sweep; reset starts a pass over the whole array
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      sweep_left <= CNT_W'(DEPTH);
    end else if (cmd.exec && erase_go) begin
      sweep_addr <= erase_base;
      sweep_left <= erase_span;
    end else if (cmd.sweep_step) begin
      sweep_addr <= sweep_addr + ADDR_BITS'(1);
      sweep_left <= sweep_left - CNT_W'(1);
    end
  end

  always_comb begin
    wr_en   = cmd.sweep_step || (cmd.exec && mem_wr);
    wr_addr = cmd.sweep_step ? sweep_addr : addr_use;
    wr_data = cmd.sweep_step ? 8'h00 : cur_mosi;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.exec && mem_rd) rd_data <= mem[addr_use];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load) begin
      miso        <= pend_mem ? rd_data : pend_miso;
      miso_driven <= pend_drv;
    end
  end

  always_comb begin
    status               = '0;
    status.slot_free     = !out_valid || out_ready;
    status.sweep_pending = (sweep_left != '0);
    status.sweep_last    = (sweep_left == CNT_W'(1));
  end

`ifndef SYNTHESIS
  a_read_buf_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_READ_BUF) |-> (read_position < needed_count))
    else $error("buffered read past its length");

  a_collect_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_COLLECT) |-> (collected_count < needed_count))
    else $error("collect count past its target");

  a_sweep_in_array: assert property (@(posedge clk) disable iff (rst)
    (sweep_left != '0) |->
      ((CNT_W+1)'(sweep_addr) + (CNT_W+1)'(sweep_left) <= (CNT_W+1)'(DEPTH)))
    else $error("zeroing sweep runs past the array");
`endif

endmodule
